// ----- rtl/rtc_three_wire_master_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the three-wire serial master
// Immediate-cycle and next-cycle implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RTC_THREE_WIRE_MASTER_TOP_MACROS_SVH
`define RTC_THREE_WIRE_MASTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RTC3W_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rtc3w check failed");
`define RTC3W_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rtc3w check failed");
`else
`define RTC3W_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RTC3W_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/rtc3w_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master package
// Shared types, command codes, frame constants and BCD helpers.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

    typedef logic [3:0] cmd_t;

    localparam cmd_t CMD_TICK        = 4'd0;
    localparam cmd_t CMD_REG_WRITE   = 4'd1;
    localparam cmd_t CMD_REG_READ    = 4'd2;
    localparam cmd_t CMD_RAM_WRITE   = 4'd3;
    localparam cmd_t CMD_RAM_READ    = 4'd4;
    localparam cmd_t CMD_CLK_BURST_W = 4'd5;
    localparam cmd_t CMD_CLK_BURST_R = 4'd6;
    localparam cmd_t CMD_RAM_BURST_W = 4'd7;
    localparam cmd_t CMD_RAM_BURST_R = 4'd8;

    localparam logic [7:0] BYTE_REG_BASE   = 8'h80;
    localparam logic [7:0] BYTE_RAM_BASE   = 8'hC0;
    localparam logic [7:0] BYTE_WP_ADDR    = 8'h8E;
    localparam logic [7:0] BYTE_WP_CLEAR   = 8'h00;
    localparam logic [7:0] BYTE_WP_SET     = 8'h80;
    localparam logic [7:0] BYTE_CLK_BURST  = 8'hBE;
    localparam logic [7:0] BYTE_RAM_BURST  = 8'hFE;
    localparam logic [7:0] BYTE_RAM_BURSTR = 8'hFF;
    localparam logic [7:0] BYTE_HALT_MASK  = 8'h7F;
    localparam logic [7:0] BYTE_CLK_STOP   = 8'h80;

    localparam logic [4:0] MAX_REG_INDEX  = 5'd8;
    localparam logic [4:0] MAX_CLK_INDEX  = 5'd6;
    localparam logic [1:0] LAST_FRAME     = 2'd2;
    localparam logic [1:0] DATA_FRAME     = 2'd1;
    localparam logic [2:0] LAST_BIT       = 3'd7;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_START     = 8'b0000_0010,
        ST_SEND_LOW  = 8'b0000_0100,
        ST_SEND_HIGH = 8'b0000_1000,
        ST_RECV_LOW  = 8'b0001_0000,
        ST_RECV_HIGH = 8'b0010_0000,
        ST_END       = 8'b0100_0000,
        ST_RELEASE   = 8'b1000_0000
    } step_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] index;
        logic [7:0] wdata;
        logic       io_in;
    } req_t;

    typedef struct packed {
        logic       ce;
        logic       sclk;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       byte_taken;
        logic       done_res;
    } res_t;

    function automatic logic is_write(input cmd_t c);
        return (c == CMD_REG_WRITE) || (c == CMD_RAM_WRITE) ||
               (c == CMD_CLK_BURST_W) || (c == CMD_RAM_BURST_W);
    endfunction

    // Shift-add-three conversion; the hundreds digit is dropped.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [11:0] d;
        d = '0;
        for (int i = 7; i >= 0; i--) begin
            if (d[3:0] >= 4'd5) d[3:0] = d[3:0] + 4'd3;
            if (d[7:4] >= 4'd5) d[7:4] = d[7:4] + 4'd3;
            if (d[11:8] >= 4'd5) d[11:8] = d[11:8] + 4'd3;
            d = {d[10:0], v[i]};
        end
        return d[7:0];
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'b0000, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, v[3:0]};
    endfunction

endpackage

// ----- rtl/rtc3w_seq.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master tick sequencer
// Holds the transaction state and computes the pin levels and result of one tick.
// ----------------------------------------------------------------------------
`include "rtc_three_wire_master_top_macros.svh"

module rtc3w_seq #(
    parameter int RAM_BYTES   = 31,
    parameter int CLOCK_BYTES = 7
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            dec_conv,
    input  rtc3w_pkg::req_t req,
    output rtc3w_pkg::res_t res
);

    localparam logic [5:0] RAM_LIM = 6'(RAM_BYTES);
    localparam logic [5:0] CLK_LIM = 6'(CLOCK_BYTES);

    rtc3w_pkg::step_t step_reg, step_next;
    logic [1:0]       frame_reg, frame_next;
    logic [2:0]       bit_reg, bit_next;
    logic [4:0]       byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    rtc3w_pkg::cmd_t  hcmd_reg, hcmd_next;
    logic [4:0]       hidx_reg, hidx_next;
    logic             ce_reg, ce_next;
    logic             sclk_reg, sclk_next;
    logic             io_reg, io_next;

    logic       cmd_ok;
    logic       in_clk;
    logic [7:0] in_load;
    logic [5:0] bc1;
    logic [5:0] fbytes;
    logic       nb_more;
    logic       nb_read;
    logic       nb_load;
    logic       nb_clk;
    logic [7:0] nb_val;
    logic [7:0] cmd_byte;
    logic [7:0] snd_byte;
    logic       rx_six;
    logic       rx_clk;
    logic       rx_sec;
    logic [7:0] rx_val;
    logic       do_next;

    always_comb begin
        unique case (req.cmd)
            rtc3w_pkg::CMD_REG_WRITE, rtc3w_pkg::CMD_REG_READ:
                cmd_ok = req.index <= rtc3w_pkg::MAX_REG_INDEX;
            rtc3w_pkg::CMD_RAM_WRITE, rtc3w_pkg::CMD_RAM_READ:
                cmd_ok = {1'b0, req.index} < RAM_LIM;
            rtc3w_pkg::CMD_CLK_BURST_W, rtc3w_pkg::CMD_CLK_BURST_R,
            rtc3w_pkg::CMD_RAM_BURST_W, rtc3w_pkg::CMD_RAM_BURST_R:
                cmd_ok = 1'b1;
            default:
                cmd_ok = 1'b0;
        endcase
    end

    assign in_clk = ((req.cmd == rtc3w_pkg::CMD_REG_WRITE) &&
                     (req.index <= rtc3w_pkg::MAX_CLK_INDEX)) ||
                    (req.cmd == rtc3w_pkg::CMD_CLK_BURST_W);
    assign in_load = !rtc3w_pkg::is_write(req.cmd) ? 8'h00 :
                     (in_clk && dec_conv) ? rtc3w_pkg::to_bcd(req.wdata) : req.wdata;

    always_comb begin
        if (frame_reg != rtc3w_pkg::DATA_FRAME) begin
            fbytes = 6'd2;
        end else if (hcmd_reg <= rtc3w_pkg::CMD_RAM_READ) begin
            fbytes = 6'd2;
        end else if (hcmd_reg <= rtc3w_pkg::CMD_CLK_BURST_R) begin
            fbytes = CLK_LIM + 6'd2;
        end else begin
            fbytes = RAM_LIM + 6'd1;
        end
    end

    assign bc1     = {1'b0, byte_reg} + 6'd1;
    assign nb_more = bc1 < fbytes;
    assign nb_read = (frame_reg == rtc3w_pkg::DATA_FRAME) && !rtc3w_pkg::is_write(hcmd_reg);
    assign nb_load = (frame_reg == rtc3w_pkg::DATA_FRAME) && (bc1 >= 6'd2) &&
                     ((hcmd_reg == rtc3w_pkg::CMD_RAM_BURST_W) ||
                      ((hcmd_reg == rtc3w_pkg::CMD_CLK_BURST_W) && (bc1 <= CLK_LIM)));
    assign nb_clk  = ((hcmd_reg == rtc3w_pkg::CMD_REG_WRITE) &&
                      (hidx_reg <= rtc3w_pkg::MAX_CLK_INDEX)) ||
                     ((hcmd_reg == rtc3w_pkg::CMD_CLK_BURST_W) &&
                      ({1'b0, byte_reg} < CLK_LIM));
    assign nb_val  = (nb_clk && dec_conv) ? rtc3w_pkg::to_bcd(req.wdata) : req.wdata;

    always_comb begin
        unique case (hcmd_reg)
            rtc3w_pkg::CMD_REG_WRITE:
                cmd_byte = rtc3w_pkg::BYTE_REG_BASE + {2'b00, hidx_reg, 1'b0};
            rtc3w_pkg::CMD_REG_READ:
                cmd_byte = rtc3w_pkg::BYTE_REG_BASE + {2'b00, hidx_reg, 1'b1};
            rtc3w_pkg::CMD_RAM_WRITE:
                cmd_byte = rtc3w_pkg::BYTE_RAM_BASE + {2'b00, hidx_reg, 1'b0};
            rtc3w_pkg::CMD_RAM_READ:
                cmd_byte = rtc3w_pkg::BYTE_RAM_BASE + {2'b00, hidx_reg, 1'b1};
            rtc3w_pkg::CMD_CLK_BURST_W:
                cmd_byte = rtc3w_pkg::BYTE_CLK_BURST;
            rtc3w_pkg::CMD_CLK_BURST_R:
                cmd_byte = rtc3w_pkg::BYTE_CLK_BURST | 8'h01;
            rtc3w_pkg::CMD_RAM_BURST_W:
                cmd_byte = rtc3w_pkg::BYTE_RAM_BURST;
            default:
                cmd_byte = rtc3w_pkg::BYTE_RAM_BURSTR;
        endcase
    end

    always_comb begin
        if (frame_reg == 2'd0) begin
            snd_byte = (byte_reg == 5'd0) ? rtc3w_pkg::BYTE_WP_ADDR : rtc3w_pkg::BYTE_WP_CLEAR;
        end else if (frame_reg != rtc3w_pkg::DATA_FRAME) begin
            snd_byte = (byte_reg == 5'd0) ? rtc3w_pkg::BYTE_WP_ADDR : rtc3w_pkg::BYTE_WP_SET;
        end else if (byte_reg == 5'd0) begin
            snd_byte = cmd_byte;
        end else if ((hcmd_reg == rtc3w_pkg::CMD_CLK_BURST_W) &&
                     ({1'b0, byte_reg} == CLK_LIM + 6'd1)) begin
            snd_byte = rtc3w_pkg::BYTE_CLK_STOP;
        end else begin
            snd_byte = shift_reg;
        end
    end

    assign rx_six = hcmd_reg == rtc3w_pkg::CMD_CLK_BURST_R;
    assign rx_clk = ((hcmd_reg == rtc3w_pkg::CMD_REG_READ) &&
                     (hidx_reg <= rtc3w_pkg::MAX_CLK_INDEX)) ||
                    (rx_six && (byte_reg != 5'd0) && ({1'b0, byte_reg} <= CLK_LIM));
    assign rx_sec = ((hcmd_reg == rtc3w_pkg::CMD_REG_READ) && (hidx_reg == 5'd0)) ||
                    (rx_six && (byte_reg == 5'd1));
    assign rx_val = !(rx_clk && dec_conv) ? shift_reg :
                    rtc3w_pkg::from_bcd(rx_sec ? (shift_reg & rtc3w_pkg::BYTE_HALT_MASK)
                                               : shift_reg);

    always_comb begin
        step_next  = step_reg;
        frame_next = frame_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        hcmd_next  = hcmd_reg;
        hidx_next  = hidx_reg;
        ce_next    = ce_reg;
        sclk_next  = sclk_reg;
        io_next    = io_reg;
        do_next    = 1'b0;
        res        = '0;
        res.busy_res = 1'b1;
        res.io_drive = 1'b1;

        unique case (step_reg)
            rtc3w_pkg::ST_IDLE: begin
                if (cmd_ok) begin
                    hcmd_next  = req.cmd;
                    hidx_next  = req.index;
                    shift_next = in_load;
                    frame_next = 2'd0;
                    byte_next  = 5'd0;
                    bit_next   = 3'd0;
                    ce_next    = 1'b1;
                    sclk_next  = 1'b0;
                    io_next    = 1'b0;
                    step_next  = rtc3w_pkg::ST_SEND_LOW;
                end else begin
                    res.busy_res = 1'b0;
                end
            end
            rtc3w_pkg::ST_START: begin
                ce_next   = 1'b1;
                sclk_next = 1'b0;
                io_next   = 1'b0;
                byte_next = 5'd0;
                bit_next  = 3'd0;
                step_next = rtc3w_pkg::ST_SEND_LOW;
            end
            rtc3w_pkg::ST_SEND_LOW: begin
                ce_next   = 1'b1;
                sclk_next = 1'b0;
                io_next   = snd_byte[bit_reg];
                step_next = rtc3w_pkg::ST_SEND_HIGH;
            end
            rtc3w_pkg::ST_SEND_HIGH: begin
                sclk_next = 1'b1;
                if (bit_reg != rtc3w_pkg::LAST_BIT) begin
                    bit_next  = bit_reg + 3'd1;
                    step_next = rtc3w_pkg::ST_SEND_LOW;
                end else begin
                    bit_next = 3'd0;
                    do_next  = 1'b1;
                end
            end
            rtc3w_pkg::ST_RECV_LOW: begin
                res.io_drive = 1'b0;
                ce_next    = 1'b1;
                sclk_next  = 1'b0;
                io_next    = 1'b1;
                shift_next = {req.io_in, shift_reg[7:1]};
                step_next  = rtc3w_pkg::ST_RECV_HIGH;
            end
            rtc3w_pkg::ST_RECV_HIGH: begin
                res.io_drive = 1'b0;
                ce_next   = 1'b1;
                sclk_next = 1'b1;
                io_next   = 1'b1;
                if (bit_reg != rtc3w_pkg::LAST_BIT) begin
                    bit_next  = bit_reg + 3'd1;
                    step_next = rtc3w_pkg::ST_RECV_LOW;
                end else begin
                    bit_next = 3'd0;
                    do_next  = 1'b1;
                    if (!(rx_six && ({1'b0, byte_reg} == CLK_LIM + 6'd1))) begin
                        res.rdata       = rx_val;
                        res.rdata_valid = 1'b1;
                    end
                end
            end
            rtc3w_pkg::ST_END: begin
                ce_next   = 1'b0;
                sclk_next = 1'b1;
                io_next   = 1'b0;
                step_next = rtc3w_pkg::ST_RELEASE;
            end
            rtc3w_pkg::ST_RELEASE: begin
                ce_next   = 1'b0;
                sclk_next = 1'b1;
                io_next   = 1'b1;
                if (frame_reg < rtc3w_pkg::LAST_FRAME) begin
                    frame_next = frame_reg + 2'd1;
                    step_next  = rtc3w_pkg::ST_START;
                end else begin
                    frame_next   = 2'd0;
                    step_next    = rtc3w_pkg::ST_IDLE;
                    res.done_res = 1'b1;
                end
            end
            default: begin
                step_next    = rtc3w_pkg::ST_IDLE;
                ce_next      = 1'b0;
                sclk_next    = 1'b1;
                io_next      = 1'b1;
                res.busy_res = 1'b0;
            end
        endcase

        if (do_next) begin
            if (nb_more) begin
                byte_next = bc1[4:0];
                if (nb_read) begin
                    step_next = rtc3w_pkg::ST_RECV_LOW;
                end else begin
                    if (nb_load) begin
                        shift_next     = nb_val;
                        res.byte_taken = 1'b1;
                    end
                    step_next = rtc3w_pkg::ST_SEND_LOW;
                end
            end else begin
                step_next = rtc3w_pkg::ST_END;
            end
        end

        res.ce     = ce_next;
        res.sclk   = sclk_next;
        res.io_out = io_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= rtc3w_pkg::ST_IDLE;
            frame_reg <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            hcmd_reg  <= rtc3w_pkg::CMD_TICK;
            hidx_reg  <= '0;
            ce_reg    <= 1'b0;
            sclk_reg  <= 1'b1;
            io_reg    <= 1'b1;
        end else if (en) begin
            step_reg  <= step_next;
            frame_reg <= frame_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            hcmd_reg  <= hcmd_next;
            hidx_reg  <= hidx_next;
            ce_reg    <= ce_next;
            sclk_reg  <= sclk_next;
            io_reg    <= io_next;
        end
    end

    `RTC3W_ASSERT_NXT(a_last_release_idles, aclk, aresetn, en && (step_reg == rtc3w_pkg::ST_RELEASE) && (frame_reg == rtc3w_pkg::LAST_FRAME), step_reg == rtc3w_pkg::ST_IDLE)
    `RTC3W_ASSERT_NXT(a_bad_request_stays_idle, aclk, aresetn, en && (step_reg == rtc3w_pkg::ST_IDLE) && !cmd_ok, (step_reg == rtc3w_pkg::ST_IDLE) && !ce_reg)
    `RTC3W_ASSERT_IMP(a_rdata_only_on_read, aclk, aresetn, en && res.rdata_valid, !rtc3w_pkg::is_write(hcmd_reg) && (hcmd_reg != rtc3w_pkg::CMD_TICK))
    `RTC3W_ASSERT_IMP(a_taken_only_on_burst_write, aclk, aresetn, en && res.byte_taken, (hcmd_reg == rtc3w_pkg::CMD_CLK_BURST_W) || (hcmd_reg == rtc3w_pkg::CMD_RAM_BURST_W))

endmodule

// ----- rtl/rtc_three_wire_master_top.sv -----
// ----------------------------------------------------------------------------
// Three-wire serial master for a real-time-clock chip
// Tick-driven master that frames register, RAM and burst transfers.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    cmd, index, wdata, io_in
//   m_        out        m_valid / m_ready    pin levels, status, read byte
//   cfg_      in         cfg_we               decimal_convert
//
// One request enters per cycle unless a full result register is not being drained.
// The request register feeds the tick sequencer, whose result is registered.
// Both stages advance together whenever the result register is empty or drained.
// Reset is synchronous; the sequencer resets to ce low, sclk and io high.
// ----------------------------------------------------------------------------
module rtc_three_wire_master_top #(
    parameter int RAM_BYTES   = 31,
    parameter int CLOCK_BYTES = 7
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_cmd,
    input  logic [4:0] s_index,
    input  logic [7:0] s_wdata,
    input  logic       s_io_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_ce,
    output logic       m_sclk,
    output logic       m_io_out,
    output logic       m_io_drive,
    output logic       m_busy_res,
    output logic [7:0] m_rdata,
    output logic       m_rdata_valid,
    output logic       m_byte_taken,
    output logic       m_done_res
);

    logic            dec_reg;
    logic            in_valid_reg;
    rtc3w_pkg::req_t in_reg;
    logic            out_valid_reg;
    rtc3w_pkg::res_t out_reg;
    rtc3w_pkg::res_t res_next;
    logic            adv;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg <= 1'b1;
        end else if (cfg_we) begin
            dec_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= '{cmd: s_cmd, index: s_index, wdata: s_wdata, io_in: s_io_in};
        end
        if (adv) begin
            out_reg <= res_next;
        end
    end

    rtc3w_seq #(
        .RAM_BYTES  (RAM_BYTES),
        .CLOCK_BYTES(CLOCK_BYTES)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .dec_conv(dec_reg),
        .req     (in_reg),
        .res     (res_next)
    );

    assign m_valid       = out_valid_reg;
    assign m_ce          = out_reg.ce;
    assign m_sclk        = out_reg.sclk;
    assign m_io_out      = out_reg.io_out;
    assign m_io_drive    = out_reg.io_drive;
    assign m_busy_res    = out_reg.busy_res;
    assign m_rdata       = out_reg.rdata;
    assign m_rdata_valid = out_reg.rdata_valid;
    assign m_byte_taken  = out_reg.byte_taken;
    assign m_done_res    = out_reg.done_res;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the three-wire serial master
// Feeds half-bit ticks carrying register, RAM and burst commands, and predicts
// the pin levels, status flags and read bytes of every tick. Each returned
// tick is checked field by field, with random stalls on both channels and
// with changes of the decimal conversion setting between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RAM_BYTES   = 31;
    localparam int CLOCK_BYTES = 7;
    localparam int STALL_LIMIT = 1000;
    localparam rtc3w_pkg::cmd_t CMD_FIRST_UNUSED = 4'd9;
    localparam rtc3w_pkg::cmd_t CMD_LAST_CODE    = 4'd15;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [3:0] s_cmd     = '0;
    logic [4:0] s_index   = '0;
    logic [7:0] s_wdata   = '0;
    logic       s_io_in   = 1'b0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_ce;
    logic       m_sclk;
    logic       m_io_out;
    logic       m_io_drive;
    logic       m_busy_res;
    logic [7:0] m_rdata;
    logic       m_rdata_valid;
    logic       m_byte_taken;
    logic       m_done_res;

    rtc_three_wire_master_top #(
        .RAM_BYTES   (RAM_BYTES),
        .CLOCK_BYTES (CLOCK_BYTES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_index       (s_index),
        .s_wdata       (s_wdata),
        .s_io_in       (s_io_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ce          (m_ce),
        .m_sclk        (m_sclk),
        .m_io_out      (m_io_out),
        .m_io_drive    (m_io_drive),
        .m_busy_res    (m_busy_res),
        .m_rdata       (m_rdata),
        .m_rdata_valid (m_rdata_valid),
        .m_byte_taken  (m_byte_taken),
        .m_done_res    (m_done_res)
    );

    rtc3w_pkg::req_t tick_queue[$];
    rtc3w_pkg::res_t pin_forecast[$];
    rtc3w_pkg::req_t offered;

    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  stall_cycles   = 0;
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  transfers_done = 0;
    int  bytes_read     = 0;
    int  phase_items    = 0;
    int  phase_cap      = 0;
    bit  steady         = 1'b0;
    bit  held_long      = 1'b0;
    bit  io_ones        = 1'b0;

    rtc3w_pkg::step_t tick_state   = rtc3w_pkg::ST_IDLE;
    logic [1:0]       frame_no     = '0;
    logic [2:0]       bit_no       = '0;
    logic [4:0]       byte_no      = '0;
    logic [7:0]       shift_reg    = '0;
    rtc3w_pkg::cmd_t  held_cmd     = rtc3w_pkg::CMD_TICK;
    logic [4:0]       held_idx     = '0;
    logic             pin_ce       = 1'b0;
    logic             pin_sclk     = 1'b1;
    logic             pin_io       = 1'b1;
    logic             decimal_mode = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] bcd_encode(input logic [7:0] v);
        int n;
        n = v;
        return 8'(((n / 10) % 10) * 16 + n % 10);
    endfunction

    function automatic logic [7:0] bcd_decode(input logic [7:0] v);
        return 8'(int'(v[7:4]) * 10 + int'(v[3:0]));
    endfunction

    function automatic bit command_accepted(input rtc3w_pkg::cmd_t c, input logic [4:0] i);
        case (c)
            rtc3w_pkg::CMD_REG_WRITE, rtc3w_pkg::CMD_REG_READ:
                return i <= rtc3w_pkg::MAX_REG_INDEX;
            rtc3w_pkg::CMD_RAM_WRITE, rtc3w_pkg::CMD_RAM_READ:
                return int'(i) < RAM_BYTES;
            rtc3w_pkg::CMD_CLK_BURST_W, rtc3w_pkg::CMD_CLK_BURST_R,
            rtc3w_pkg::CMD_RAM_BURST_W, rtc3w_pkg::CMD_RAM_BURST_R:
                return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit writes(input rtc3w_pkg::cmd_t c);
        return c == rtc3w_pkg::CMD_REG_WRITE || c == rtc3w_pkg::CMD_RAM_WRITE ||
               c == rtc3w_pkg::CMD_CLK_BURST_W || c == rtc3w_pkg::CMD_RAM_BURST_W;
    endfunction

    function automatic logic [7:0] host_byte(input logic [7:0] v, input int k);
        bit clock_reg;
        clock_reg = (held_cmd == rtc3w_pkg::CMD_REG_WRITE &&
                     held_idx <= rtc3w_pkg::MAX_CLK_INDEX) ||
                    (held_cmd == rtc3w_pkg::CMD_CLK_BURST_W && k < CLOCK_BYTES);
        return (clock_reg && decimal_mode) ? bcd_encode(v) : v;
    endfunction

    function automatic int frame_len();
        if (frame_no != rtc3w_pkg::DATA_FRAME) return 2;
        if (held_cmd <= rtc3w_pkg::CMD_RAM_READ) return 2;
        if (held_cmd <= rtc3w_pkg::CMD_CLK_BURST_R) return CLOCK_BYTES + 2;
        return RAM_BYTES + 1;
    endfunction

    function automatic logic [7:0] command_byte();
        case (held_cmd)
            rtc3w_pkg::CMD_REG_WRITE:
                return rtc3w_pkg::BYTE_REG_BASE + 8'(2 * held_idx);
            rtc3w_pkg::CMD_REG_READ:
                return rtc3w_pkg::BYTE_REG_BASE + 8'(2 * held_idx + 1);
            rtc3w_pkg::CMD_RAM_WRITE:
                return rtc3w_pkg::BYTE_RAM_BASE + 8'(2 * held_idx);
            rtc3w_pkg::CMD_RAM_READ:
                return rtc3w_pkg::BYTE_RAM_BASE + 8'(2 * held_idx + 1);
            rtc3w_pkg::CMD_CLK_BURST_W: return rtc3w_pkg::BYTE_CLK_BURST;
            rtc3w_pkg::CMD_CLK_BURST_R: return rtc3w_pkg::BYTE_CLK_BURST + 8'd1;
            rtc3w_pkg::CMD_RAM_BURST_W: return rtc3w_pkg::BYTE_RAM_BURST;
            default:                    return rtc3w_pkg::BYTE_RAM_BURSTR;
        endcase
    endfunction

    function automatic logic [7:0] outgoing_byte();
        if (frame_no == 2'd0)
            return (byte_no == 0) ? rtc3w_pkg::BYTE_WP_ADDR : rtc3w_pkg::BYTE_WP_CLEAR;
        if (frame_no != rtc3w_pkg::DATA_FRAME)
            return (byte_no == 0) ? rtc3w_pkg::BYTE_WP_ADDR : rtc3w_pkg::BYTE_WP_SET;
        if (byte_no == 0) return command_byte();
        if (held_cmd == rtc3w_pkg::CMD_CLK_BURST_W && byte_no == CLOCK_BYTES + 1)
            return rtc3w_pkg::BYTE_CLK_STOP;
        return shift_reg;
    endfunction

    // Next byte of the frame, or its end; returns 1 when a burst write byte is latched.
    function automatic logic advance_byte(input logic [7:0] wd);
        logic taken;
        taken = 1'b0;
        if (int'(byte_no) + 1 < frame_len()) begin
            byte_no = byte_no + 5'd1;
            if (frame_no == rtc3w_pkg::DATA_FRAME && !writes(held_cmd)) begin
                tick_state = rtc3w_pkg::ST_RECV_LOW;
            end else begin
                if (frame_no == rtc3w_pkg::DATA_FRAME && byte_no >= 2 &&
                    (held_cmd == rtc3w_pkg::CMD_RAM_BURST_W ||
                     (held_cmd == rtc3w_pkg::CMD_CLK_BURST_W &&
                      byte_no <= CLOCK_BYTES))) begin
                    shift_reg = host_byte(wd, int'(byte_no) - 1);
                    taken = 1'b1;
                end
                tick_state = rtc3w_pkg::ST_SEND_LOW;
            end
        end else begin
            tick_state = rtc3w_pkg::ST_END;
        end
        return taken;
    endfunction

    function automatic rtc3w_pkg::res_t serial_tick(input rtc3w_pkg::req_t rq);
        rtc3w_pkg::res_t r;
        logic [7:0]      v;
        bit              burst_rd;
        bit              clock_byte;
        bit              seconds_byte;
        r = '0;
        r.busy_res = 1'b1;
        r.io_drive = 1'b1;
        case (tick_state)
            rtc3w_pkg::ST_IDLE: begin
                if (!command_accepted(rq.cmd, rq.index)) begin
                    r.busy_res = 1'b0;
                end else begin
                    held_cmd  = rq.cmd;
                    held_idx  = rq.index;
                    shift_reg = writes(rq.cmd) ? host_byte(rq.wdata, 0) : 8'h00;
                    frame_no  = '0;
                    byte_no   = '0;
                    bit_no    = '0;
                    {pin_ce, pin_sclk, pin_io} = 3'b100;
                    tick_state = rtc3w_pkg::ST_SEND_LOW;
                end
            end
            rtc3w_pkg::ST_START: begin
                {pin_ce, pin_sclk, pin_io} = 3'b100;
                byte_no    = '0;
                bit_no     = '0;
                tick_state = rtc3w_pkg::ST_SEND_LOW;
            end
            rtc3w_pkg::ST_SEND_LOW: begin
                v = outgoing_byte();
                {pin_ce, pin_sclk, pin_io} = {2'b10, v[bit_no]};
                tick_state = rtc3w_pkg::ST_SEND_HIGH;
            end
            rtc3w_pkg::ST_SEND_HIGH: begin
                pin_sclk = 1'b1;
                if (bit_no < rtc3w_pkg::LAST_BIT) begin
                    bit_no     = bit_no + 3'd1;
                    tick_state = rtc3w_pkg::ST_SEND_LOW;
                end else begin
                    bit_no      = '0;
                    r.byte_taken = advance_byte(rq.wdata);
                end
            end
            rtc3w_pkg::ST_RECV_LOW: begin
                r.io_drive = 1'b0;
                {pin_ce, pin_sclk, pin_io} = 3'b101;
                shift_reg  = {rq.io_in, shift_reg[7:1]};
                tick_state = rtc3w_pkg::ST_RECV_HIGH;
            end
            rtc3w_pkg::ST_RECV_HIGH: begin
                r.io_drive = 1'b0;
                {pin_ce, pin_sclk, pin_io} = 3'b111;
                if (bit_no < rtc3w_pkg::LAST_BIT) begin
                    bit_no     = bit_no + 3'd1;
                    tick_state = rtc3w_pkg::ST_RECV_LOW;
                end else begin
                    bit_no       = '0;
                    v            = shift_reg;
                    burst_rd     = held_cmd == rtc3w_pkg::CMD_CLK_BURST_R;
                    clock_byte   = (held_cmd == rtc3w_pkg::CMD_REG_READ &&
                                    held_idx <= rtc3w_pkg::MAX_CLK_INDEX) ||
                                   (burst_rd && byte_no <= CLOCK_BYTES);
                    seconds_byte = (held_cmd == rtc3w_pkg::CMD_REG_READ && held_idx == 0) ||
                                   (burst_rd && byte_no == 1);
                    if (clock_byte && decimal_mode) begin
                        if (seconds_byte) v = v & rtc3w_pkg::BYTE_HALT_MASK;
                        v = bcd_decode(v);
                    end
                    if (!(burst_rd && byte_no == CLOCK_BYTES + 1)) begin
                        r.rdata       = v;
                        r.rdata_valid = 1'b1;
                    end
                    r.byte_taken = advance_byte(rq.wdata);
                end
            end
            rtc3w_pkg::ST_END: begin
                {pin_ce, pin_sclk, pin_io} = 3'b010;
                tick_state = rtc3w_pkg::ST_RELEASE;
            end
            default: begin
                {pin_ce, pin_sclk, pin_io} = 3'b011;
                if (frame_no < rtc3w_pkg::LAST_FRAME) begin
                    frame_no   = frame_no + 2'd1;
                    tick_state = rtc3w_pkg::ST_START;
                end else begin
                    frame_no   = '0;
                    tick_state = rtc3w_pkg::ST_IDLE;
                    r.done_res = 1'b1;
                end
            end
        endcase
        r.ce     = pin_ce;
        r.sclk   = pin_sclk;
        r.io_out = pin_io;
        return r;
    endfunction

    // Driver: offers queued requests and works out the expected tick on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pin_forecast.push_back(serial_tick(offered));
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && !steady && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 11);
                end
                if (send_gap > 0 || tick_queue.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    offered = tick_queue.pop_front();
                    s_valid <= 1'b1;
                    s_cmd   <= offered.cmd;
                    s_index <= offered.index;
                    s_wdata <= offered.wdata;
                    s_io_in <= offered.io_in;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: checks each returned tick against the oldest forecast.
    always @(posedge aclk) begin
        rtc3w_pkg::res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_done_res) transfers_done++;
                if (m_rdata_valid) bytes_read++;
                if (pin_forecast.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = pin_forecast.pop_front();
                    check_field("ce", want.ce, m_ce);
                    check_field("sclk", want.sclk, m_sclk);
                    check_field("io_out", want.io_out, m_io_out);
                    check_field("io_drive", want.io_drive, m_io_drive);
                    check_field("busy_res", want.busy_res, m_busy_res);
                    check_field("rdata", want.rdata, m_rdata);
                    check_field("rdata_valid", want.rdata_valid, m_rdata_valid);
                    check_field("byte_taken", want.byte_taken, m_byte_taken);
                    check_field("done_res", want.done_res, m_done_res);
                end
            end
            if (results_seen == 400 && !held_long) begin
                held_long = 1'b1;
                recv_gap  = 80;
            end else if (recv_gap == 0 && !steady && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 11);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_wdata();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 99)) : 8'($urandom);
    endfunction

    function automatic int transfer_ticks(input rtc3w_pkg::cmd_t c);
        int data_bytes;
        if (c <= rtc3w_pkg::CMD_RAM_READ) data_bytes = 2;
        else if (c <= rtc3w_pkg::CMD_CLK_BURST_R) data_bytes = CLOCK_BYTES + 2;
        else data_bytes = RAM_BYTES + 1;
        return 9 + 16 * (4 + data_bytes);
    endfunction

    task automatic queue_item(input rtc3w_pkg::cmd_t c, input logic [4:0] i,
                              input logic [7:0] w);
        rtc3w_pkg::req_t rq;
        if (phase_items < phase_cap) begin
            rq.cmd   = c;
            rq.index = i;
            rq.wdata = w;
            rq.io_in = io_ones ? 1'b1 : 1'($urandom);
            tick_queue.push_back(rq);
        end
        phase_items++;
    endtask

    // The command is followed by the ticks of its transfer; commands inside them are
    // ignored. A positive slack adds plain ticks, a negative one cuts the transfer short.
    task automatic queue_transfer(input rtc3w_pkg::cmd_t c, input logic [4:0] i,
                                  input logic [7:0] w, input int slack);
        int n;
        n = transfer_ticks(c) - 1;
        queue_item(c, i, w);
        for (int k = 0; k < n + slack; k++) begin
            queue_item(k < n ? rtc3w_pkg::cmd_t'($urandom_range(0, CMD_LAST_CODE))
                             : rtc3w_pkg::CMD_TICK,
                       5'($urandom), pick_wdata());
        end
    endtask

    task automatic queue_noise();
        case ($urandom_range(0, 3))
            0: queue_item(rtc3w_pkg::cmd_t'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)),
                          5'($urandom), 8'($urandom));
            1: queue_item($urandom_range(0, 1) ? rtc3w_pkg::CMD_REG_WRITE
                                               : rtc3w_pkg::CMD_REG_READ,
                          5'($urandom_range(rtc3w_pkg::MAX_REG_INDEX + 1, 31)),
                          8'($urandom));
            2: queue_item($urandom_range(0, 1) ? rtc3w_pkg::CMD_RAM_WRITE
                                               : rtc3w_pkg::CMD_RAM_READ,
                          5'(RAM_BYTES), 8'($urandom));
            default: queue_item(rtc3w_pkg::CMD_TICK, 5'($urandom), 8'($urandom));
        endcase
        repeat ($urandom_range(1, 3)) queue_item(rtc3w_pkg::CMD_TICK, 5'($urandom),
                                                 8'($urandom));
    endtask

    task automatic fill_random(input int budget);
        int   pick;
        int   slack;
        bit   rd;
        phase_items = 0;
        phase_cap   = budget;
        while (phase_items < budget) begin
            pick  = $urandom_range(0, 99);
            rd    = 1'($urandom);
            slack = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(1, 20))
                                                : int'($urandom_range(0, 3));
            if (pick < 35) begin
                queue_transfer(rd ? rtc3w_pkg::CMD_REG_READ : rtc3w_pkg::CMD_REG_WRITE,
                               5'($urandom_range(0, rtc3w_pkg::MAX_REG_INDEX)),
                               pick_wdata(), slack);
            end else if (pick < 60) begin
                queue_transfer(rd ? rtc3w_pkg::CMD_RAM_READ : rtc3w_pkg::CMD_RAM_WRITE,
                               5'($urandom_range(0, RAM_BYTES - 1)), pick_wdata(), slack);
            end else if (pick < 75) begin
                queue_transfer(rd ? rtc3w_pkg::CMD_CLK_BURST_R : rtc3w_pkg::CMD_CLK_BURST_W,
                               5'($urandom), pick_wdata(), slack);
            end else if (pick < 82) begin
                queue_transfer(rd ? rtc3w_pkg::CMD_RAM_BURST_R : rtc3w_pkg::CMD_RAM_BURST_W,
                               5'($urandom), pick_wdata(), slack);
            end else begin
                queue_noise();
            end
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (tick_queue.size() != 0 || s_valid || pin_forecast.size() != 0);
    endtask

    task automatic set_conversion(input logic v);
        drain();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        decimal_mode = v;
        @(negedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        phase_items = 0;
        phase_cap   = 1 << 30;
        queue_transfer(rtc3w_pkg::CMD_REG_WRITE, 5'd0, 8'd59, 0);
        queue_transfer(rtc3w_pkg::CMD_REG_WRITE, rtc3w_pkg::MAX_REG_INDEX, 8'hFF, 0);
        io_ones = 1'b1;
        queue_transfer(rtc3w_pkg::CMD_REG_READ, 5'd0, 8'h00, 0);
        queue_transfer(rtc3w_pkg::CMD_CLK_BURST_R, 5'd31, 8'h00, 0);
        io_ones = 1'b0;
        queue_transfer(rtc3w_pkg::CMD_RAM_READ, 5'(RAM_BYTES - 1), 8'h00, 0);
        queue_transfer(rtc3w_pkg::CMD_CLK_BURST_W, 5'd0, 8'd99, 0);
        queue_item(CMD_FIRST_UNUSED, 5'd0, 8'h00);
        queue_item(CMD_LAST_CODE, 5'd31, 8'hFF);
        queue_item(rtc3w_pkg::CMD_REG_READ, rtc3w_pkg::MAX_REG_INDEX + 5'd1, 8'h00);
        queue_item(rtc3w_pkg::CMD_REG_WRITE, 5'd31, 8'hFF);
        queue_item(rtc3w_pkg::CMD_RAM_READ, 5'(RAM_BYTES), 8'h00);
        queue_item(rtc3w_pkg::CMD_RAM_WRITE, 5'd31, 8'h00);
        queue_item(rtc3w_pkg::CMD_TICK, 5'd0, 8'h00);

        set_conversion(1'b0);
        fill_random(75);
        set_conversion(1'b1);
        fill_random(75);
        set_conversion(1'b0);
        fill_random(75);
        set_conversion(1'b1);
        steady = 1'b1;
        fill_random(75);

        drain();
        repeat (8) @(posedge aclk);
        $display("Checked %0d ticks: %0d transfers completed, %0d bytes read back,",
                 results_seen, transfers_done, bytes_read);
        $display("with decimal conversion both on and off and stalls on both channels.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
